// File: design/pds_pkg.sv
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants of the centerline PD steering block.
// ----------------------------------------------------------------------------
package pds_pkg;

   localparam int MAX_ROWS_DEFAULT = 64;

   localparam int COL_W   = 8;
   localparam int GAIN_W  = 16;
   localparam int PWM_W   = 16;
   localparam int ERR_W   = 9;
   localparam int DIFF_W  = ERR_W + 1;
   localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
   localparam int PROD_W  = GAIN_W + 1 + DIFF_W;
   localparam int DRIVE_W = PROD_W + 1;
   localparam int SCALED_W = DRIVE_W - 8;
   localparam int RAW_W   = SCALED_W + 1;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_ADDR_W = CSR_IDX_W + 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_PROP    = 3'd0,
      REG_GAIN_DERIV   = 3'd1,
      REG_PWM_CENTRE   = 3'd2,
      REG_PWM_UPPER    = 3'd3,
      REG_PWM_LOWER    = 3'd4,
      REG_IMAGE_CENTRE = 3'd5
   } reg_index_type;

   localparam logic [GAIN_W-1:0] GAIN_PROP_RESET    = 16'd6144;
   localparam logic [GAIN_W-1:0] GAIN_DERIV_RESET   = 16'd20;
   localparam logic [PWM_W-1:0]  PWM_CENTRE_RESET   = 16'd3400;
   localparam logic [PWM_W-1:0]  PWM_UPPER_RESET    = 16'd4150;
   localparam logic [PWM_W-1:0]  PWM_LOWER_RESET    = 16'd2650;
   localparam logic [COL_W-1:0]  IMAGE_CENTRE_RESET = 8'd80;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_prop;
      logic [GAIN_W-1:0] gain_deriv;
      logic [PWM_W-1:0]  pwm_centre;
      logic [PWM_W-1:0]  pwm_upper;
      logic [PWM_W-1:0]  pwm_lower;
      logic [COL_W-1:0]  image_centre;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV,
      OP_SIGN,
      OP_MULP,
      OP_MULD,
      OP_ADD,
      OP_SCALE,
      OP_DONE
   } op_type;

   typedef struct packed {
      logic   row_take;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

// File: design/pds_if.sv
// ----------------------------------------------------------------------------
// pds_req_if / pds_rsp_if
// Row and result channels of the centerline PD steering block.
// ----------------------------------------------------------------------------
interface pds_req_if;
   logic                          valid;
   logic                          ready;
   logic [pds_pkg::COL_W-1:0]     centre_column;
   logic                          last_row;

   modport source (output valid, output centre_column, output last_row, input ready);
   modport sink   (input valid, input centre_column, input last_row, output ready);
endinterface

interface pds_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pds_pkg::PWM_W-1:0]     steer_pwm;
   logic signed [pds_pkg::ERR_W-1:0] steer_error;
   logic                          no_line;

   modport source (output valid, output steer_pwm, output steer_error, output no_line,
                   input ready);
   modport sink   (input valid, input steer_pwm, input steer_error, input no_line,
                   output ready);
endinterface

// File: design/centerline_pd_steering.sv
// ----------------------------------------------------------------------------
// centerline_pd_steering
// PD servo steering from the fitted track-centre column of each image row.
// ----------------------------------------------------------------------------
// Rows are taken one per clock while the block collects a frame. The row
// flagged last closes the frame: the block then stops taking rows while it
// walks the load step, the restoring divider that forms the mean offset one
// quotient bit per cycle, the sign, P product, D product, sum and scale
// steps, and the step that posts the result. A result waiting in the output
// register does not block rows of the next frame; only the end of that next
// frame waits for it to be taken, and that wait lengthens the pause above.
module centerline_pd_steering #(
   parameter int MAX_ROWS = pds_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   pds_req_if.sink                           req_bus,
   pds_rsp_if.source                         rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pds_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pds_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pds_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   pds_pkg::cfg_type    cfg;
   pds_pkg::cmd_type    cmd;
   pds_pkg::status_type status;

   pds_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last_row),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .cmd       (cmd)
   );

   pds_dp #(
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .centre_column (req_bus.centre_column),
      .status        (status),
      .steer_pwm     (rsp_bus.steer_pwm),
      .steer_error   (rsp_bus.steer_error),
      .no_line       (rsp_bus.no_line)
   );

endmodule

// File: design/pds_csr.sv
// ----------------------------------------------------------------------------
// pds_csr
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module pds_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pds_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pds_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pds_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output pds_pkg::cfg_type                  cfg
);

   pds_pkg::cfg_type                      cfg_ff, cfg_in;
   logic [pds_pkg::CSR_IDX_W-1:0]         idx;
   logic                                  wr_en;

   assign idx        = csr_paddr[pds_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            pds_pkg::REG_GAIN_PROP:    cfg_in.gain_prop    = csr_pwdata[15:0];
            pds_pkg::REG_GAIN_DERIV:   cfg_in.gain_deriv   = csr_pwdata[15:0];
            pds_pkg::REG_PWM_CENTRE:   cfg_in.pwm_centre   = csr_pwdata[15:0];
            pds_pkg::REG_PWM_UPPER:    cfg_in.pwm_upper    = csr_pwdata[15:0];
            pds_pkg::REG_PWM_LOWER:    cfg_in.pwm_lower    = csr_pwdata[15:0];
            pds_pkg::REG_IMAGE_CENTRE: cfg_in.image_centre = csr_pwdata[7:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         pds_pkg::REG_GAIN_PROP:    csr_prdata = {16'd0, cfg_ff.gain_prop};
         pds_pkg::REG_GAIN_DERIV:   csr_prdata = {16'd0, cfg_ff.gain_deriv};
         pds_pkg::REG_PWM_CENTRE:   csr_prdata = {16'd0, cfg_ff.pwm_centre};
         pds_pkg::REG_PWM_UPPER:    csr_prdata = {16'd0, cfg_ff.pwm_upper};
         pds_pkg::REG_PWM_LOWER:    csr_prdata = {16'd0, cfg_ff.pwm_lower};
         pds_pkg::REG_IMAGE_CENTRE: csr_prdata = {24'd0, cfg_ff.image_centre};
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_prop    <= pds_pkg::GAIN_PROP_RESET;
         cfg_ff.gain_deriv   <= pds_pkg::GAIN_DERIV_RESET;
         cfg_ff.pwm_centre   <= pds_pkg::PWM_CENTRE_RESET;
         cfg_ff.pwm_upper    <= pds_pkg::PWM_UPPER_RESET;
         cfg_ff.pwm_lower    <= pds_pkg::PWM_LOWER_RESET;
         cfg_ff.image_centre <= pds_pkg::IMAGE_CENTRE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/pds_ctrl.sv
// ----------------------------------------------------------------------------
// pds_ctrl
// Sequencer: takes rows, then walks the end-of-frame divide and PD steps.
// ----------------------------------------------------------------------------
module pds_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   input  logic                 rsp_ready,
   input  pds_pkg::status_type  status,
   output logic                 req_ready,
   output logic                 rsp_valid,
   output pds_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      S_ROWS,
      S_LOAD,
      S_DIV,
      S_SIGN,
      S_MULP,
      S_MULD,
      S_ADD,
      S_SCALE,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      row_take;
   logic      slot_free;

   assign req_ready = (state_ff == S_ROWS);
   assign row_take  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.row_take = row_take;
      cmd.op       = pds_pkg::OP_NONE;
      unique case (state_ff)
         S_ROWS: begin
            if (row_take && req_last) state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.op   = pds_pkg::OP_LOAD;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = pds_pkg::OP_DIV;
            if (status.div_done) state_in = S_SIGN;
         end
         S_SIGN: begin
            cmd.op   = pds_pkg::OP_SIGN;
            state_in = S_MULP;
         end
         S_MULP: begin
            cmd.op   = pds_pkg::OP_MULP;
            state_in = S_MULD;
         end
         S_MULD: begin
            cmd.op   = pds_pkg::OP_MULD;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.op   = pds_pkg::OP_ADD;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.op   = pds_pkg::OP_SCALE;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (slot_free) begin
               cmd.op       = pds_pkg::OP_DONE;
               rsp_valid_in = 1'b1;
               state_in     = S_ROWS;
            end
         end
         default: state_in = S_ROWS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ROWS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_last_row_starts_frame_end: assert property (@(posedge clock) disable iff (reset)
      (row_take && req_last) |=> (state_ff == S_LOAD))
      else $error("last row did not start the frame-end sequence");

   a_done_posts_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && slot_free) |=> (rsp_valid_ff && state_ff == S_ROWS))
      else $error("finished frame did not post a result");

endmodule

// File: design/pds_dp.sv
// ----------------------------------------------------------------------------
// pds_dp
// Datapath: row accumulation, bit-serial divider, PD multiply and clamp.
// ----------------------------------------------------------------------------
module pds_dp #(
   parameter int MAX_ROWS = pds_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pds_pkg::cmd_type                    cmd,
   input  pds_pkg::cfg_type                    cfg,
   input  logic [pds_pkg::COL_W-1:0]           centre_column,
   output pds_pkg::status_type                 status,
   output logic [pds_pkg::PWM_W-1:0]           steer_pwm,
   output logic signed [pds_pkg::ERR_W-1:0]    steer_error,
   output logic                                no_line
);

   localparam int CNT_W  = $clog2(MAX_ROWS + 1);
   localparam int SUM_W  = pds_pkg::ERR_W + CNT_W;
   localparam int STEP_W = $clog2(SUM_W);
   localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_ROWS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);
   localparam int ERR_W  = pds_pkg::ERR_W;
   localparam int RAW_W  = pds_pkg::RAW_W;

   // frame accumulators
   logic signed [SUM_W-1:0]        sum_ff;
   logic [CNT_W-1:0]               cnt_ff;
   logic signed [ERR_W-1:0]        prev_ff;

   // divider
   logic [SUM_W-1:0]               quo_ff;
   logic [CNT_W-1:0]               rem_ff;
   logic [CNT_W-1:0]               divisor_ff;
   logic [STEP_W-1:0]              step_ff;
   logic                           neg_ff;
   logic                           none_ff;

   // PD arithmetic
   logic signed [ERR_W-1:0]               err_ff;
   logic signed [pds_pkg::PROD_W-1:0]     prod_p_ff;
   logic signed [pds_pkg::PROD_W-1:0]     prod_d_ff;
   logic signed [pds_pkg::DRIVE_W-1:0]    drive_ff;
   logic signed [RAW_W-1:0]               raw_ff;

   logic [pds_pkg::PWM_W-1:0]             steer_pwm_ff;
   logic signed [ERR_W-1:0]               steer_error_ff;
   logic                                  no_line_ff;

   logic signed [ERR_W-1:0]               offset;
   logic [SUM_W-1:0]                      sum_mag;
   logic [CNT_W:0]                        rem_sh;
   logic [CNT_W:0]                        rem_diff;
   logic signed [ERR_W-1:0]               quo_s;
   logic signed [pds_pkg::GAIN_W:0]       gain_p_s;
   logic signed [pds_pkg::GAIN_W:0]       gain_d_s;
   logic signed [pds_pkg::DIFF_W-1:0]     err_diff;
   logic signed [pds_pkg::PROD_P_W-1:0]   prod_p;
   logic signed [pds_pkg::PROD_W-1:0]     prod_d;
   logic signed [pds_pkg::DRIVE_W-1:0]    drive_adj;
   logic signed [pds_pkg::SCALED_W-1:0]   scaled;
   logic signed [RAW_W-1:0]               upper_s;
   logic signed [RAW_W-1:0]               lower_s;
   logic signed [RAW_W-1:0]               clamp_hi;
   logic signed [RAW_W-1:0]               clamp_lo;

   assign offset   = $signed({1'b0, centre_column}) - $signed({1'b0, cfg.image_centre});
   assign sum_mag  = sum_ff[SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;

   assign rem_sh   = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, divisor_ff};
   assign quo_s    = $signed(quo_ff[ERR_W-1:0]);

   assign gain_p_s = $signed({1'b0, cfg.gain_prop});
   assign gain_d_s = $signed({1'b0, cfg.gain_deriv});
   assign err_diff = $signed({err_ff[ERR_W-1], err_ff}) - $signed({prev_ff[ERR_W-1], prev_ff});
   assign prod_p   = gain_p_s * err_ff;
   assign prod_d   = gain_d_s * err_diff;

   // round toward zero before dropping the Q8.8 fraction
   assign drive_adj = drive_ff + (drive_ff[pds_pkg::DRIVE_W-1] ?
                      pds_pkg::DRIVE_W'(255) : pds_pkg::DRIVE_W'(0));
   assign scaled    = drive_adj[pds_pkg::DRIVE_W-1:8];

   assign upper_s  = $signed({{(RAW_W-pds_pkg::PWM_W){1'b0}}, cfg.pwm_upper});
   assign lower_s  = $signed({{(RAW_W-pds_pkg::PWM_W){1'b0}}, cfg.pwm_lower});
   assign clamp_hi = (raw_ff > upper_s) ? upper_s : raw_ff;
   assign clamp_lo = (clamp_hi < lower_s) ? lower_s : clamp_hi;

   assign status.div_done = (step_ff == '0);
   assign steer_pwm       = steer_pwm_ff;
   assign steer_error     = steer_error_ff;
   assign no_line         = no_line_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         cnt_ff  <= '0;
         prev_ff <= '0;
      end else begin
         if (cmd.op == pds_pkg::OP_LOAD) begin
            sum_ff <= '0;
            cnt_ff <= '0;
         end else if (cmd.row_take && centre_column != '0 && cnt_ff < MAX_CNT) begin
            sum_ff <= sum_ff + {{(SUM_W-ERR_W){offset[ERR_W-1]}}, offset};
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.op == pds_pkg::OP_DONE) prev_ff <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         pds_pkg::OP_LOAD: begin
            quo_ff     <= sum_mag;
            rem_ff     <= '0;
            divisor_ff <= cnt_ff;
            step_ff    <= LAST_STEP;
            neg_ff     <= sum_ff[SUM_W-1];
            none_ff    <= (cnt_ff == '0);
         end
         pds_pkg::OP_DIV: begin
            // restoring divide, one quotient bit per cycle
            if (!rem_diff[CNT_W]) begin
               rem_ff <= rem_diff[CNT_W-1:0];
            end else begin
               rem_ff <= rem_sh[CNT_W-1:0];
            end
            quo_ff  <= {quo_ff[SUM_W-2:0], !rem_diff[CNT_W]};
            step_ff <= step_ff - 1'b1;
         end
         pds_pkg::OP_SIGN: begin
            if (none_ff) begin
               err_ff <= '0;
            end else begin
               err_ff <= neg_ff ? quo_s : -quo_s;
            end
         end
         pds_pkg::OP_MULP: begin
            prod_p_ff <= {{(pds_pkg::PROD_W-pds_pkg::PROD_P_W){prod_p[pds_pkg::PROD_P_W-1]}},
                          prod_p};
         end
         pds_pkg::OP_MULD: begin
            prod_d_ff <= prod_d;
         end
         pds_pkg::OP_ADD: begin
            drive_ff <= {prod_p_ff[pds_pkg::PROD_W-1], prod_p_ff}
                      + {prod_d_ff[pds_pkg::PROD_W-1], prod_d_ff};
         end
         pds_pkg::OP_SCALE: begin
            raw_ff <= {scaled[pds_pkg::SCALED_W-1], scaled}
                    + $signed({{(RAW_W-pds_pkg::PWM_W){1'b0}}, cfg.pwm_centre});
         end
         pds_pkg::OP_DONE: begin
            steer_pwm_ff   <= (err_ff == '0) ? cfg.pwm_centre : clamp_lo[pds_pkg::PWM_W-1:0];
            steer_error_ff <= err_ff;
            no_line_ff     <= none_ff;
         end
         default: begin
         end
      endcase
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_CNT)
      else $error("valid row count went past the row limit");

   a_error_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == pds_pkg::OP_SIGN) |=> (err_ff != $signed({1'b1, {(ERR_W-1){1'b0}}})))
      else $error("steering error left its range");

   a_no_line_centres: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == pds_pkg::OP_DONE && none_ff) |=>
      (no_line_ff && steer_error_ff == '0 && steer_pwm_ff == $past(cfg.pwm_centre)))
      else $error("frame without a line did not steer straight");

endmodule

// File: tb/sv/tb_centerline_pd_steering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_centerline_pd_steering
// Streams image rows into the steering block under several register settings
// and checks every frame result against a cycle-free PD steering predictor.
// ----------------------------------------------------------------------------
module tb_centerline_pd_steering;

   localparam int ROW_LIMIT     = pds_pkg::MAX_ROWS_DEFAULT;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 400000;
   localparam logic [pds_pkg::CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [pds_pkg::CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef struct {
      logic [pds_pkg::COL_W-1:0] col;
      logic                      last;
   } row_item_type;

   typedef struct {
      logic [pds_pkg::PWM_W-1:0]        pwm;
      logic signed [pds_pkg::ERR_W-1:0] err;
      logic                             no_line;
   } steer_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [pds_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [pds_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [pds_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   pds_req_if req_bus ();
   pds_rsp_if rsp_bus ();

   centerline_pd_steering #(.MAX_ROWS(ROW_LIMIT)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // predictor state and register copy
   pds_pkg::cfg_type model_cfg;
   int      offset_acc;
   int      rows_counted;
   int      last_err;

   row_item_type     pending_rows[$];
   steer_result_type expected_steer[$];

   bit idle_off;
   int req_gap;
   int rsp_stall;
   int fail_count;
   int rows_accepted;
   int frames_checked;
   int no_line_frames;
   int settings_applied;
   int cycle_count;

   function automatic bit steer_row(input row_item_type r, output steer_result_type s);
      int     err_i;
      longint gp;
      longint gd;
      longint pc;
      longint drive;
      longint pwm;
      bit     none;
      if (r.col != 0 && rows_counted < ROW_LIMIT) begin
         offset_acc += int'(r.col) - int'(model_cfg.image_centre);
         rows_counted++;
      end
      if (!r.last) return 1'b0;
      none = (rows_counted == 0);
      err_i = none ? 0 : -(offset_acc / rows_counted);
      gp = model_cfg.gain_prop;
      gd = model_cfg.gain_deriv;
      pc = model_cfg.pwm_centre;
      drive = gp * err_i + gd * (err_i - last_err);
      pwm = drive / 256 + pc;
      if (pwm > longint'(model_cfg.pwm_upper)) pwm = model_cfg.pwm_upper;
      if (pwm < longint'(model_cfg.pwm_lower)) pwm = model_cfg.pwm_lower;
      if (err_i == 0) pwm = pc;
      last_err = err_i;
      offset_acc = 0;
      rows_counted = 0;
      s.pwm = pwm[pds_pkg::PWM_W-1:0];
      s.err = err_i[pds_pkg::ERR_W-1:0];
      s.no_line = none;
      return 1'b1;
   endfunction

   // row driver
   always @(posedge clock) begin
      row_item_type     taken;
      steer_result_type res;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            taken.col = req_bus.centre_column;
            taken.last = req_bus.last_row;
            if (steer_row(taken, res)) expected_steer.push_back(res);
            rows_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
               req_bus.centre_column <= pds_pkg::COL_W'($urandom());
               req_bus.last_row <= 1'($urandom());
            end else if (!idle_off && $urandom_range(9) == 0) begin
               req_gap = $urandom_range(14, 1) - 1;
               req_bus.valid <= 1'b0;
               req_bus.centre_column <= pds_pkg::COL_W'($urandom());
               req_bus.last_row <= 1'($urandom());
            end else if (pending_rows.size() > 0) begin
               taken = pending_rows.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.centre_column <= taken.col;
               req_bus.last_row <= taken.last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      steer_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_steer.size() == 0) begin
               $error("unexpected result: steer_pwm %0d steer_error %0d no_line %0b",
                      rsp_bus.steer_pwm, rsp_bus.steer_error, rsp_bus.no_line);
               fail_count++;
            end else begin
               want = expected_steer.pop_front();
               frames_checked++;
               if (want.no_line) no_line_frames++;
               if (rsp_bus.steer_pwm !== want.pwm) begin
                  $error("steer_pwm: expected %0d, got %0d", want.pwm, rsp_bus.steer_pwm);
                  fail_count++;
               end
               if (rsp_bus.steer_error !== want.err) begin
                  $error("steer_error: expected %0d, got %0d", want.err, rsp_bus.steer_error);
                  fail_count++;
               end
               if (rsp_bus.no_line !== want.no_line) begin
                  $error("no_line: expected %0b, got %0b", want.no_line, rsp_bus.no_line);
                  fail_count++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else if (!idle_off && $urandom_range(9) == 0) begin
            rsp_stall = $urandom_range(14, 1) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_steer.size());
         $display("** centerline_pd_steering: FAILED **");
         $finish;
      end
   end

   task automatic csr_write(input logic [pds_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] value);
      logic [pds_pkg::CSR_DATA_W-1:0] data;
      data = $urandom();
      data[15:0] = value;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         pds_pkg::REG_GAIN_PROP:    model_cfg.gain_prop = data[pds_pkg::GAIN_W-1:0];
         pds_pkg::REG_GAIN_DERIV:   model_cfg.gain_deriv = data[pds_pkg::GAIN_W-1:0];
         pds_pkg::REG_PWM_CENTRE:   model_cfg.pwm_centre = data[pds_pkg::PWM_W-1:0];
         pds_pkg::REG_PWM_UPPER:    model_cfg.pwm_upper = data[pds_pkg::PWM_W-1:0];
         pds_pkg::REG_PWM_LOWER:    model_cfg.pwm_lower = data[pds_pkg::PWM_W-1:0];
         pds_pkg::REG_IMAGE_CENTRE: model_cfg.image_centre = data[pds_pkg::COL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_cfg(input logic [15:0] gp, input logic [15:0] gd,
                              input logic [15:0] pc, input logic [15:0] pu,
                              input logic [15:0] pl, input logic [7:0] ic);
      csr_write(pds_pkg::REG_GAIN_PROP, gp);
      csr_write(pds_pkg::REG_GAIN_DERIV, gd);
      csr_write(pds_pkg::REG_PWM_CENTRE, pc);
      csr_write(pds_pkg::REG_PWM_UPPER, pu);
      csr_write(pds_pkg::REG_PWM_LOWER, pl);
      csr_write(pds_pkg::REG_IMAGE_CENTRE, {8'h00, ic});
      settings_applied++;
   endtask

   task automatic push_row(input logic [pds_pkg::COL_W-1:0] col, input logic last);
      row_item_type r;
      r.col = col;
      r.last = last;
      pending_rows.push_back(r);
   endtask

   // one frame: mostly short, now and then longer than the row limit
   task automatic add_frame(output int n);
      int zero_pct;
      int near;
      int c;
      n = ($urandom_range(9) == 0) ? $urandom_range(80, 60) : $urandom_range(12, 1);
      zero_pct = ($urandom_range(11) == 0) ? 100 : 15;
      near = ($urandom_range(3) == 0);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < zero_pct) c = 0;
         else if (near) c = int'(model_cfg.image_centre) + $urandom_range(6) - 3;
         else c = $urandom_range(255, 1);
         if (c < 1) c = 1;
         if (c > 255) c = 255;
         if (zero_pct == 100) c = 0;
         push_row(c[pds_pkg::COL_W-1:0], i == n - 1);
      end
   endtask

   task automatic add_frames(input int rows);
      int added;
      int n;
      added = 0;
      while (added < rows) begin
         add_frame(n);
         added += n;
      end
   endtask

   // drain everything, then give the block time to settle before any write
   task automatic finish_phase();
      while (pending_rows.size() > 0 || req_bus.valid || expected_steer.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_settings();
      logic [15:0] pc;
      logic [15:0] gp;
      pc = 16'($urandom_range(6000, 1000));
      gp = ($urandom_range(7) == 0) ? 16'($urandom()) : 16'($urandom_range(12000));
      program_cfg(gp, 16'($urandom_range(4000)), pc, 16'(pc + $urandom_range(2000)),
                  16'(pc - $urandom_range(900)), 8'($urandom_range(255)));
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.centre_column = '0;
      req_bus.last_row = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      model_cfg.gain_prop = pds_pkg::GAIN_PROP_RESET;
      model_cfg.gain_deriv = pds_pkg::GAIN_DERIV_RESET;
      model_cfg.pwm_centre = pds_pkg::PWM_CENTRE_RESET;
      model_cfg.pwm_upper = pds_pkg::PWM_UPPER_RESET;
      model_cfg.pwm_lower = pds_pkg::PWM_LOWER_RESET;
      model_cfg.image_centre = pds_pkg::IMAGE_CENTRE_RESET;
      offset_acc = 0;
      rows_counted = 0;
      last_err = 0;
      idle_off = 1'b0;
      settings_applied = 1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed frames under reset settings
      push_row(8'd0, 1'b1);       // no valid row
      push_row(8'd255, 1'b1);     // far right, clamps low
      push_row(8'd1, 1'b1);       // far left, clamps high
      push_row(8'd80, 1'b1);      // on centre, forced centre pwm
      push_row(8'd82, 1'b1);
      push_row(8'd82, 1'b1);      // same error twice, no derivative
      push_row(8'd100, 1'b0);     // mean truncates to zero
      push_row(8'd0, 1'b0);
      push_row(8'd61, 1'b1);
      push_row(8'd79, 1'b0);      // negative mean
      push_row(8'd81, 1'b0);
      push_row(8'd77, 1'b1);
      push_row(8'd0, 1'b0);       // no line after a nonzero error
      push_row(8'd0, 1'b1);
      push_row(8'd78, 1'b0);
      push_row(8'd255, 1'b0);
      push_row(8'd1, 1'b1);
      finish_phase();

      // widest settings, plus writes to unmapped addresses
      program_cfg(16'hFFFF, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h0000, 8'hFF);
      csr_write(REG_SPARE_LO, 16'($urandom()));
      csr_write(REG_SPARE_HI, 16'($urandom()));
      // more valid rows than the row limit in one frame
      for (int i = 0; i < ROW_LIMIT + 6; i++)
         push_row(8'($urandom_range(255, 1)), i == ROW_LIMIT + 5);
      add_frames(140);
      finish_phase();

      // zero proportional gain, image centre 0, upper bound below lower bound
      program_cfg(16'h0000, 16'hFFFF, 16'd2000, 16'd1000, 16'd3000, 8'h00);
      add_frames(210);
      finish_phase();

      for (int p = 0; p < 4; p++) begin
         if (p == 0)
            program_cfg(pds_pkg::GAIN_PROP_RESET, pds_pkg::GAIN_DERIV_RESET,
                        pds_pkg::PWM_CENTRE_RESET, pds_pkg::PWM_UPPER_RESET,
                        pds_pkg::PWM_LOWER_RESET, pds_pkg::IMAGE_CENTRE_RESET);
         else
            random_settings();
         if (p == 3) idle_off = 1'b1;
         add_frames(210);
         finish_phase();
      end

      $display("%0d rows and %0d frame results (%0d without a line) checked",
               rows_accepted, frames_checked, no_line_frames);
      $display("across %0d register settings in %0d cycles", settings_applied, cycle_count);
      if (fail_count == 0) begin
         $display("** centerline_pd_steering: PASSED **");
      end else begin
         $display("** centerline_pd_steering: FAILED **");
      end
      $finish;
   end

endmodule
